// File: design/cvh_pkg.sv
// ----------------------------------------------------------------------------
// Convex hull edge extraction package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package cvh_pkg;

   localparam int DEF_MAX_VERTICES = 32;
   localparam int DEF_COORD_BITS   = 24;

   localparam int EDGE_W  = 5;
   localparam int NTOL_W  = 49;
   localparam int PTOL_W  = 62;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 64;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_NEXT  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_RSVD  = 2'd3;

   localparam logic REG_NTOL = 1'b0;
   localparam logic REG_PTOL = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NEXT,
      S_RDA,
      S_RDB,
      S_RDC,
      S_RDD,
      S_NRM,
      S_DEG,
      S_PRD,
      S_PCAP,
      S_PMUL,
      S_PCHK
   } cvh_state_type;

endpackage

// File: design/cvh_vstore.sv
// ----------------------------------------------------------------------------
// Vertex store
// Single-port write, single-port read memory with a registered read.
// ----------------------------------------------------------------------------
module cvh_vstore #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/convex_hull_edge_extraction.sv
// ----------------------------------------------------------------------------
// Convex hull edge extraction
// Brute-force hull scan over stored points with one shared multiplier.
// ----------------------------------------------------------------------------
// Loads, clears and ignored beats are taken one per cycle while no next-edge
// request is in progress. A next-edge request holds the input while it checks
// the face pairs already given out, tests triples and tests each point against a
// face (a point equal to a corner is skipped, and the loop closes after the last
// point), bounded by the single shared multiplier, used for each point and normal.
// The reset is synchronous; it clears the point count, scan, edge marks and tolerances.
// ----------------------------------------------------------------------------
module convex_hull_edge_extraction
   import cvh_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [EDGE_W-1:0]            rsp_edge_from,
   output logic [EDGE_W-1:0]            rsp_edge_to,
   output logic                         rsp_edge_valid,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_AW-1:0]            csr_paddr,
   input  logic [CSR_DW-1:0]            csr_pwdata,
   output logic [CSR_DW-1:0]            csr_prdata,
   output logic                         csr_pready
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int TW = IW + 1;
   localparam int CW = IW + 2;
   localparam int CB = COORD_BITS;
   localparam int VW = 3 * CB;
   localparam int DW = CB + 1;
   localparam int BW = CB + 2;
   localparam int NW = 2 * CB + 3;
   localparam int H  = CB + 1;
   localparam int PW = DW + BW;
   localparam int AW = 3 * CB + 6;
   localparam int WN = ((NW > NTOL_W) ? NW : NTOL_W) + 2;
   localparam int WP = ((AW > PTOL_W) ? AW : PTOL_W) + 2;

   cvh_state_type state_ff, state_in;

   logic [NTOL_W-1:0] ntol_ff;
   logic [PTOL_W-1:0] ptol_ff;
   logic [TW-1:0]     total_ff;
   logic [CW-1:0]     first_ff, second_ff, third_ff;
   logic [1:0]        pend_ff;
   logic              done_ff;
   logic [MAX_VERTICES-1:0] seen_ff [MAX_VERTICES];

   logic [VW-1:0]          a_ff, b_ff, c_ff;
   logic signed [DW-1:0]   e1_ff [3];
   logic signed [DW-1:0]   e2_ff [3];
   logic signed [DW-1:0]   d_ff [3];
   logic signed [NW-1:0]   n_ff [3];
   logic signed [PW-1:0]   prod_ff;
   logic signed [AW-1:0]   acc_ff;
   logic [2:0]             step_ff;
   logic [TW-1:0]          pt_ff;
   logic                   side_set_ff, side_neg_ff;

   logic              rsp_valid_ff;
   logic [EDGE_W-1:0] rsp_from_ff, rsp_to_ff;
   logic              rsp_ev_ff;
   logic              rsp_emit;

   logic          wr_en;
   logic [IW-1:0] rd_addr;
   logic [VW-1:0] rd_data;
   logic          req_fire, slot_free, cfg_write;

   logic signed [CB-1:0] rd_c [3];
   logic signed [CB-1:0] a_c [3];

   logic signed [DW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic [2:0]           tag;
   logic [1:0]           comp;
   logic [1:0]           ssel;

   logic [CW-1:0] adv_first, adv_second, adv_third;
   logic          adv_done;

   logic [CW-1:0] from_idx, to_idx, lo_idx, hi_idx;
   logic          pair_seen;
   logic          degenerate, dist_within, same_pt, end_of_pts, scan_end;

   logic signed [WN-1:0] nx [3];
   logic signed [WN-1:0] ntx;
   logic signed [WP-1:0] ax, ptx;

   cvh_vstore #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (VW)
   ) u_vstore (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[IW-1:0]),
      .wr_data ({req_coord_x, req_coord_y, req_coord_z}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         rd_c[d] = rd_data[(2 - d) * CB +: CB];
         a_c[d]  = a_ff[(2 - d) * CB +: CB];
      end
   end

   // Triple advance in lexicographic order.
   always_comb begin
      adv_first  = first_ff;
      adv_second = second_ff;
      adv_third  = third_ff + CW'(1);
      adv_done   = 1'b0;
      if (adv_third >= CW'(total_ff)) begin
         adv_second = second_ff + CW'(1);
         adv_third  = second_ff + CW'(2);
         if (adv_third >= CW'(total_ff)) begin
            adv_first  = first_ff + CW'(1);
            adv_second = first_ff + CW'(2);
            adv_third  = first_ff + CW'(3);
            adv_done   = adv_third >= CW'(total_ff);
         end
      end
   end

   always_comb begin
      case (pend_ff)
         2'd3:    begin from_idx = first_ff;  to_idx = second_ff; end
         2'd2:    begin from_idx = second_ff; to_idx = third_ff;  end
         default: begin from_idx = third_ff;  to_idx = first_ff;  end
      endcase
      lo_idx    = (from_idx < to_idx) ? from_idx : to_idx;
      hi_idx    = (from_idx < to_idx) ? to_idx : from_idx;
      pair_seen = seen_ff[lo_idx[IW-1:0]][hi_idx[IW-1:0]];
   end

   always_comb begin
      ntx = $signed(WN'(ntol_ff));
      for (int d = 0; d < 3; d++) begin
         nx[d] = WN'(n_ff[d]);
      end
      degenerate = (nx[0] <= ntx) && (nx[0] >= -ntx) &&
                   (nx[1] <= ntx) && (nx[1] >= -ntx) &&
                   (nx[2] <= ntx) && (nx[2] >= -ntx);
      ptx         = $signed(WP'(ptol_ff));
      ax          = WP'(acc_ff);
      dist_within = (ax <= ptx) && (ax >= -ptx);
      same_pt     = (rd_data == a_ff) || (rd_data == b_ff) || (rd_data == c_ff);
      end_of_pts  = pt_ff >= total_ff;
      scan_end    = done_ff || (third_ff >= CW'(total_ff));
   end

   // Shared multiplier operand selection.
   always_comb begin
      comp  = step_ff[2:1];
      ssel  = (comp == 2'd3) ? 2'd2 : comp;
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_NRM) begin
         case (step_ff)
            3'd0:    begin mul_a = e1_ff[1]; mul_b = BW'(e2_ff[2]); end
            3'd1:    begin mul_a = e1_ff[2]; mul_b = BW'(e2_ff[1]); end
            3'd2:    begin mul_a = e1_ff[2]; mul_b = BW'(e2_ff[0]); end
            3'd3:    begin mul_a = e1_ff[0]; mul_b = BW'(e2_ff[2]); end
            3'd4:    begin mul_a = e1_ff[0]; mul_b = BW'(e2_ff[1]); end
            default: begin mul_a = e1_ff[1]; mul_b = BW'(e2_ff[0]); end
         endcase
      end else begin
         mul_a = d_ff[ssel];
         if (step_ff[0]) begin
            mul_b = n_ff[ssel][NW-1:H];
         end else begin
            mul_b = $signed({1'b0, n_ff[ssel][H-1:0]});
         end
      end
      tag = step_ff - 3'd1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_mode == MODE_NEXT) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (slot_free) begin
               if (pend_ff != 2'd0) begin
                  if (!pair_seen) begin
                     state_in = S_IDLE;
                  end
               end else if (scan_end) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RDA;
               end
            end
         end
         S_RDA: state_in = S_RDB;
         S_RDB: state_in = S_RDC;
         S_RDC: state_in = S_RDD;
         S_RDD: state_in = S_NRM;
         S_NRM: begin
            if (step_ff == 3'd6) begin
               state_in = S_DEG;
            end
         end
         S_DEG: state_in = degenerate ? S_NEXT : S_PRD;
         S_PRD: state_in = end_of_pts ? S_NEXT : S_PCAP;
         S_PCAP: state_in = same_pt ? S_PRD : S_PMUL;
         S_PMUL: begin
            if (step_ff == 3'd6) begin
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (!dist_within && side_set_ff && (side_neg_ff != acc_ff[AW-1])) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_PRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != S_IDLE;
      wr_en     = req_fire && req_mode == MODE_LOAD && total_ff < TW'(MAX_VERTICES);
      rsp_emit  = (state_ff == S_NEXT) && slot_free &&
                  ((pend_ff != 2'd0) ? !pair_seen : scan_end);
      unique case (state_ff)
         S_RDA:   rd_addr = first_ff[IW-1:0];
         S_RDB:   rd_addr = second_ff[IW-1:0];
         S_RDC:   rd_addr = third_ff[IW-1:0];
         S_PRD:   rd_addr = pt_ff[IW-1:0];
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ntol_ff      <= '0;
         ptol_ff      <= '0;
         total_ff     <= '0;
         first_ff     <= CW'(0);
         second_ff    <= CW'(1);
         third_ff     <= CW'(2);
         pend_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_VERTICES; r++) begin
            seen_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (cfg_write) begin
            if (csr_paddr[3] == REG_PTOL) begin
               ptol_ff <= csr_pwdata[PTOL_W-1:0];
            end else begin
               ntol_ff <= csr_pwdata[NTOL_W-1:0];
            end
         end
         if (rsp_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if ((req_mode == MODE_LOAD && wr_en) || req_mode == MODE_CLEAR) begin
                     first_ff  <= CW'(0);
                     second_ff <= CW'(1);
                     third_ff  <= CW'(2);
                     pend_ff   <= '0;
                     done_ff   <= 1'b0;
                  end
                  if (wr_en) begin
                     total_ff <= total_ff + TW'(1);
                  end
                  if (req_mode == MODE_CLEAR) begin
                     total_ff <= '0;
                     for (int r = 0; r < MAX_VERTICES; r++) begin
                        seen_ff[r] <= '0;
                     end
                  end
               end
            end
            S_NEXT: begin
               if (slot_free) begin
                  if (pend_ff != 2'd0) begin
                     pend_ff <= pend_ff - 2'd1;
                     if (pend_ff == 2'd1) begin
                        first_ff  <= adv_first;
                        second_ff <= adv_second;
                        third_ff  <= adv_third;
                        done_ff   <= done_ff | adv_done;
                     end
                     if (!pair_seen) begin
                        seen_ff[lo_idx[IW-1:0]][hi_idx[IW-1:0]] <= 1'b1;
                        rsp_from_ff  <= EDGE_W'(from_idx);
                        rsp_to_ff    <= EDGE_W'(to_idx);
                        rsp_ev_ff    <= 1'b1;
                     end
                  end else if (scan_end) begin
                     done_ff      <= 1'b1;
                     rsp_from_ff  <= '0;
                     rsp_to_ff    <= '0;
                     rsp_ev_ff    <= 1'b0;
                  end
               end
            end
            S_DEG: begin
               if (degenerate) begin
                  first_ff  <= adv_first;
                  second_ff <= adv_second;
                  third_ff  <= adv_third;
                  done_ff   <= done_ff | adv_done;
               end
            end
            S_PRD: begin
               if (end_of_pts) begin
                  pend_ff <= 2'd3;
               end
            end
            S_PCHK: begin
               if (!dist_within && side_set_ff && (side_neg_ff != acc_ff[AW-1])) begin
                  first_ff  <= adv_first;
                  second_ff <= adv_second;
                  third_ff  <= adv_third;
                  done_ff   <= done_ff | adv_done;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Datapath registers of the shared unit.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_RDB: a_ff <= rd_data;
         S_RDC: begin
            b_ff <= rd_data;
            for (int d = 0; d < 3; d++) begin
               e1_ff[d] <= DW'(rd_c[d]) - DW'(a_c[d]);
            end
         end
         S_RDD: begin
            c_ff    <= rd_data;
            step_ff <= '0;
            for (int d = 0; d < 3; d++) begin
               e2_ff[d] <= DW'(rd_c[d]) - DW'(a_c[d]);
            end
         end
         S_NRM: begin
            step_ff <= step_ff + 3'd1;
            if (step_ff != 3'd0) begin
               if (tag[0]) begin
                  n_ff[tag[2:1]] <= n_ff[tag[2:1]] - NW'(prod_ff);
               end else begin
                  n_ff[tag[2:1]] <= NW'(prod_ff);
               end
            end
         end
         S_DEG: begin
            pt_ff       <= '0;
            side_set_ff <= 1'b0;
         end
         S_PCAP: begin
            if (same_pt) begin
               pt_ff <= pt_ff + TW'(1);
            end
            acc_ff  <= '0;
            step_ff <= '0;
            for (int d = 0; d < 3; d++) begin
               d_ff[d] <= DW'(rd_c[d]) - DW'(a_c[d]);
            end
         end
         S_PMUL: begin
            step_ff <= step_ff + 3'd1;
            if (step_ff != 3'd0) begin
               if (tag[0]) begin
                  acc_ff <= acc_ff + (AW'(prod_ff) <<< H);
               end else begin
                  acc_ff <= acc_ff + AW'(prod_ff);
               end
            end
         end
         S_PCHK: begin
            pt_ff <= pt_ff + TW'(1);
            if (!dist_within) begin
               side_set_ff <= 1'b1;
               side_neg_ff <= acc_ff[AW-1];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_from  = rsp_from_ff;
   assign rsp_edge_to    = rsp_to_ff;
   assign rsp_edge_valid = rsp_ev_ff;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = (csr_paddr[3] == REG_PTOL) ? CSR_DW'(ptol_ff) : CSR_DW'(ntol_ff);

endmodule

// File: design/cvh_checker.sv
// ----------------------------------------------------------------------------
// Convex hull edge extraction checker
// Port-level properties of the hull edge block, bound to the top level.
// ----------------------------------------------------------------------------
module cvh_checker
   import cvh_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_mode,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [EDGE_W-1:0] rsp_edge_from,
   input logic [EDGE_W-1:0] rsp_edge_to,
   input logic              rsp_edge_valid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_from) &&
      $stable(rsp_edge_to) && $stable(rsp_edge_valid))
      else $error("Stalled result beat changed.");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_edge_valid |-> rsp_edge_from == '0 && rsp_edge_to == '0)
      else $error("End-of-scan beat carries a vertex index.");

   a_edge_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_valid |-> rsp_edge_from != rsp_edge_to)
      else $error("Edge beat joins a vertex to itself.");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_NEXT |=> req_stall)
      else $error("Input accepted while an edge request is in progress.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat shown straight after reset.");

endmodule

bind convex_hull_edge_extraction cvh_checker u_cvh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_edge_from  (rsp_edge_from),
   .rsp_edge_to    (rsp_edge_to),
   .rsp_edge_valid (rsp_edge_valid)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Convex hull edge extraction testbench
// Loads small point sets, asks for hull edges and compares every edge beat with
// a behavioural hull scan kept in a scoreboard, across tolerance settings and
// idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import cvh_pkg::*;

   typedef struct {
      logic [EDGE_W-1:0] src;
      logic [EDGE_W-1:0] dst;
      logic              valid;
   } hull_edge_type;

   class hull_scoreboard_type;
      logic signed [23:0] pts[32][3];
      int                 total;
      bit                 seen[32][32];
      int                 fi, se, th, pend;
      bit                 done;
      logic [NTOL_W-1:0]  ntol;
      logic [PTOL_W-1:0]  ptol;
      hull_edge_type      pending_edges[$];
      int                 errors;

      function new();
         total = 0;
         ntol = '0;
         ptol = '0;
         errors = 0;
         foreach (seen[a, b]) seen[a][b] = 0;
         restart();
      endfunction

      function void restart();
         fi = 0; se = 1; th = 2; pend = 0; done = 0;
      endfunction

      function void advance();
         th++;
         if (th >= total) begin
            se++;
            th = se + 1;
            if (th >= total) begin
               fi++;
               se = fi + 1;
               th = se + 1;
               if (th >= total) done = 1;
            end
         end
      endfunction

      function bit in_tol(logic signed [127:0] v, logic [63:0] tol);
         logic [127:0] mag;
         mag = v[127] ? -v : v;
         return mag <= {64'd0, tol};
      endfunction

      function bit same(int p, int q);
         return pts[p][0] == pts[q][0] && pts[p][1] == pts[q][1] && pts[p][2] == pts[q][2];
      endfunction

      function bit is_face(int i, int j, int k);
         logic signed [127:0] a[3], e1[3], e2[3], n[3], plane_dist, diff;
         int side, s;
         for (int d = 0; d < 3; d++) begin
            a[d] = 128'(pts[i][d]);
            e1[d] = 128'(pts[j][d]);
            e1[d] = e1[d] - a[d];
            e2[d] = 128'(pts[k][d]);
            e2[d] = e2[d] - a[d];
         end
         n[0] = e1[1] * e2[2] - e1[2] * e2[1];
         n[1] = e1[2] * e2[0] - e1[0] * e2[2];
         n[2] = e1[0] * e2[1] - e1[1] * e2[0];
         if (in_tol(n[0], 64'(ntol)) && in_tol(n[1], 64'(ntol)) && in_tol(n[2], 64'(ntol)))
            return 0;
         side = 0;
         for (int p = 0; p < total; p++) begin
            if (same(p, i) || same(p, j) || same(p, k)) continue;
            plane_dist = '0;
            for (int d = 0; d < 3; d++) begin
               diff = 128'(pts[p][d]);
               plane_dist = plane_dist + (diff - a[d]) * n[d];
            end
            if (in_tol(plane_dist, 64'(ptol))) continue;
            s = plane_dist[127] ? -1 : 1;
            if (side != 0 && side != s) return 0;
            side = s;
         end
         return 1;
      endfunction

      function hull_edge_type next_edge();
         hull_edge_type r;
         int f, t, lo, hi;
         forever begin
            if (pend > 0) begin
               if (pend == 3) begin
                  f = fi; t = se;
               end else if (pend == 2) begin
                  f = se; t = th;
               end else begin
                  f = th; t = fi;
               end
               pend--;
               if (pend == 0) advance();
               lo = f < t ? f : t;
               hi = f < t ? t : f;
               if (!seen[lo][hi]) begin
                  seen[lo][hi] = 1;
                  r.src = EDGE_W'(f); r.dst = EDGE_W'(t); r.valid = 1;
                  return r;
               end
               continue;
            end
            if (!done && th >= total) done = 1;
            if (done) begin
               r.src = '0; r.dst = '0; r.valid = 0;
               return r;
            end
            if (is_face(fi, se, th)) pend = 3;
            else advance();
         end
      endfunction

      function void note(logic [1:0] mode, logic signed [23:0] x, y, z);
         case (mode)
            MODE_LOAD: begin
               if (total < 32) begin
                  pts[total][0] = x; pts[total][1] = y; pts[total][2] = z;
                  total++;
                  restart();
               end
            end
            MODE_CLEAR: begin
               total = 0;
               foreach (seen[a, b]) seen[a][b] = 0;
               restart();
            end
            MODE_NEXT: pending_edges = {pending_edges, next_edge()};
            default: ;
         endcase
      endfunction

      function void check(logic [EDGE_W-1:0] src, dst, logic valid);
         hull_edge_type e;
         if (pending_edges.size() == 0) begin
            $error("edge beat with none expected: from %0d to %0d valid %0d", src, dst, valid);
            errors++;
            return;
         end
         e = pending_edges.pop_front();
         if (src !== e.src) begin
            $error("edge_from: expected %0d, got %0d", e.src, src);
            errors++;
         end
         if (dst !== e.dst) begin
            $error("edge_to: expected %0d, got %0d", e.dst, dst);
            errors++;
         end
         if (valid !== e.valid) begin
            $error("edge_valid: expected %0d, got %0d", e.valid, valid);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic [1:0]               req_mode = MODE_LOAD;
   logic signed [23:0]       req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic [EDGE_W-1:0]        rsp_edge_from, rsp_edge_to;
   logic                     rsp_edge_valid;
   logic                     csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0]        csr_paddr = '0;
   logic [CSR_DW-1:0]        csr_pwdata = '0;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   hull_scoreboard_type      hull_sb = new();
   int                       send_idle_pct = 0;
   int                       stall_pct = 0;
   int                       hold_left = 0;
   int                       items_sent = 0;

   convex_hull_edge_extraction uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_edge_from(rsp_edge_from),
      .rsp_edge_to(rsp_edge_to), .rsp_edge_valid(rsp_edge_valid),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom % 100) < stall_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         hull_sb.check(rsp_edge_from, rsp_edge_to, rsp_edge_valid);
   end

   task automatic send_item(logic [1:0] mode, logic signed [23:0] x, y, z);
      @(negedge clock);
      while (($urandom % 100) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_mode = mode;
      req_coord_x = x;
      req_coord_y = y;
      req_coord_z = z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hull_sb.note(mode, x, y, z);
      items_sent++;
   endtask

   task automatic write_reg(logic reg_index, logic [CSR_DW-1:0] value);
      @(negedge clock);
      req_valid = 0;
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = {reg_index, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_index == REG_NTOL) hull_sb.ntol = value[NTOL_W-1:0];
      else hull_sb.ptol = value[PTOL_W-1:0];
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (hull_sb.pending_edges.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick(int style);
      case (style)
         0: return 24'($urandom);
         1: return 24'(int'($urandom_range(0, 128)) - 64);
         2: return 24'((int'($urandom_range(0, 2)) - 1) * 4096);
         default: begin
            case ($urandom_range(0, 3))
               0: return 24'sh7FFFFF;
               1: return 24'sh800000;
               2: return 24'sd0;
               default: return -24'sd1;
            endcase
         end
      endcase
   endfunction

   task automatic run_set(int n, int style, int nreq);
      int roll;
      send_item(MODE_CLEAR, pick(0), pick(0), pick(0));
      for (int i = 0; i < n; i++) send_item(MODE_LOAD, pick(style), pick(style), pick(style));
      for (int r = 0; r < nreq; r++) begin
         roll = $urandom % 100;
         if (roll < 3) send_item(MODE_RSVD, pick(0), pick(0), pick(0));
         else if (roll < 7) send_item(MODE_LOAD, pick(style), pick(style), pick(style));
         else send_item(MODE_NEXT, pick(0), pick(0), pick(0));
      end
   endtask

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      write_reg(REG_NTOL, 64'd0);
      write_reg(REG_PTOL, 64'd0);
      send_item(MODE_NEXT, 24'sd0, 24'sd0, 24'sd0);
      send_item(MODE_LOAD, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
      send_item(MODE_LOAD, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
      send_item(MODE_NEXT, 24'sd0, 24'sd0, 24'sd0);
      send_item(MODE_LOAD, 24'sd0, 24'sd0, 24'sd0);
      send_item(MODE_LOAD, 24'sd0, 24'sd0, 24'sd0);
      send_item(MODE_NEXT, 24'sd0, 24'sd0, 24'sd0);
      send_item(MODE_LOAD, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
      send_item(MODE_LOAD, 24'sd4096, 24'sd4096, 24'sd4096);
      for (int i = 0; i < 8; i++) send_item(MODE_NEXT, 24'sd0, 24'sd0, 24'sd0);
      send_item(MODE_RSVD, -24'sd1, -24'sd1, -24'sd1);
      send_item(MODE_CLEAR, 24'sd0, 24'sd0, 24'sd0);
      send_item(MODE_NEXT, 24'sd0, 24'sd0, 24'sd0);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         case (phase)
            2: begin write_reg(REG_NTOL, 64'({NTOL_W{1'b1}})); write_reg(REG_PTOL, 64'd0); end
            6: begin write_reg(REG_NTOL, 64'd0); write_reg(REG_PTOL, 64'({PTOL_W{1'b1}})); end
            10: begin
               write_reg(REG_NTOL, 64'({NTOL_W{1'b1}}));
               write_reg(REG_PTOL, 64'({PTOL_W{1'b1}}));
            end
            0, 4: begin write_reg(REG_NTOL, 64'd0); write_reg(REG_PTOL, 64'd0); end
            default: begin
               write_reg(REG_NTOL, 64'($urandom_range(0, 5000)));
               write_reg(REG_PTOL, {$urandom, $urandom} & 64'hFFFFF);
            end
         endcase
         if (phase == 5) hold_left = 400;
         if (phase == 3) run_set(33, 0, 4);
         while (items_sent < 40 + (phase + 1) * 96) begin
            n = $urandom_range(3, 9);
            if ($urandom % 10 == 0) n = $urandom_range(0, 2);
            run_set(n, $urandom_range(0, 3), 3 * n + 2);
         end
         drain();
      end

      @(negedge clock);
      req_valid = 0;
      drain();
      if (hull_sb.errors == 0 && hull_sb.pending_edges.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: sim.f
design/cvh_pkg.sv
design/cvh_vstore.sv
design/convex_hull_edge_extraction.sv
design/cvh_checker.sv
tb/sv/testbench.sv
